@@ sv/tss_pkg.sv @@
package tss_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int EDGE_W = 33;              // corner difference
    localparam int PROD_W = 66;              // edge * edge
    localparam int MAT_W  = 67;              // det or adjugate product entry
    localparam int MAG_W  = 66;              // magnitude of a MAT_W value
    localparam int QB     = 60;              // quotient bits; entries saturate at 2^60-1
    localparam int ENT_W  = QB + 1;          // signed gradient entry
    localparam int SUM_W  = ENT_W + 1;       // sum of two entries
    localparam int SMAG_W = SUM_W - 1;       // magnitude of such a sum
    localparam int LO_W   = 31;              // low split for squaring
    localparam int HI_W   = SMAG_W - LO_W;
    localparam int SQ_W   = 2 * SMAG_W;      // square of a magnitude
    localparam int ROOT_W = 62;              // square root bits
    localparam int RAD_W  = 2 * ROOT_W;      // radicand
    localparam int DIV_LAT  = QB + 2;        // divider: input reg, QB steps, output reg
    localparam int FRONT_LAT = 4;

    typedef struct packed {
        logic signed [31:0] rest_ax;
        logic signed [31:0] rest_ay;
        logic signed [31:0] rest_bx;
        logic signed [31:0] rest_by;
        logic signed [31:0] rest_cx;
        logic signed [31:0] rest_cy;
        logic signed [31:0] goal_ax;
        logic signed [31:0] goal_ay;
        logic signed [31:0] goal_bx;
        logic signed [31:0] goal_by;
        logic signed [31:0] goal_cx;
        logic signed [31:0] goal_cy;
    } t_item;

    typedef struct packed {
        logic [30:0]        stretch_major;
        logic signed [31:0] stretch_minor;
        logic               rest_degenerate;
    } t_result;

    // per-item control traveling alongside the datapath
    typedef struct packed {
        logic valid;
        logic degen;   // det R == 0
        logic tzero;   // det T == 0
        logic dneg;    // det F < 0
    } t_flags;

endpackage

@@ sv/tss_front.sv @@
module tss_front #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  tss_pkg::t_item                i_item,
    output tss_pkg::t_flags               o_flags,
    output logic [tss_pkg::MAG_W+FRAC_BITS-1:0] o_num [4],
    output logic                          o_neg [4],
    output logic [tss_pkg::MAG_W-1:0]     o_den
);
    import tss_pkg::*;

    localparam int NUM_W = MAG_W + FRAC_BITS;

    // edges: 0 r00, 1 r10, 2 r01, 3 r11, 4 t00, 5 t10, 6 t01, 7 t11
    logic signed [EDGE_W-1:0] r_e [8];
    logic signed [PROD_W-1:0] r_p [12];
    logic signed [MAT_W-1:0]  r_detr, r_dett;
    logic signed [MAT_W-1:0]  r_m [4];
    logic [NUM_W-1:0]         r_num [4];
    logic                     r_neg [4];
    logic [MAG_W-1:0]         r_den;
    logic                     r_v1, r_v2, r_v3;
    t_flags                   r_flags;

    logic                     n_flip;

    always_ff @(posedge i_clk) begin
        r_e[0] <= EDGE_W'(i_item.rest_bx) - EDGE_W'(i_item.rest_ax);
        r_e[1] <= EDGE_W'(i_item.rest_by) - EDGE_W'(i_item.rest_ay);
        r_e[2] <= EDGE_W'(i_item.rest_cx) - EDGE_W'(i_item.rest_ax);
        r_e[3] <= EDGE_W'(i_item.rest_cy) - EDGE_W'(i_item.rest_ay);
        r_e[4] <= EDGE_W'(i_item.goal_bx) - EDGE_W'(i_item.goal_ax);
        r_e[5] <= EDGE_W'(i_item.goal_by) - EDGE_W'(i_item.goal_ay);
        r_e[6] <= EDGE_W'(i_item.goal_cx) - EDGE_W'(i_item.goal_ax);
        r_e[7] <= EDGE_W'(i_item.goal_cy) - EDGE_W'(i_item.goal_ay);
    end

    always_ff @(posedge i_clk) begin
        r_p[0]  <= PROD_W'(r_e[0]) * PROD_W'(r_e[3]);
        r_p[1]  <= PROD_W'(r_e[2]) * PROD_W'(r_e[1]);
        r_p[2]  <= PROD_W'(r_e[4]) * PROD_W'(r_e[7]);
        r_p[3]  <= PROD_W'(r_e[6]) * PROD_W'(r_e[5]);
        r_p[4]  <= PROD_W'(r_e[4]) * PROD_W'(r_e[3]);
        r_p[5]  <= PROD_W'(r_e[6]) * PROD_W'(r_e[1]);
        r_p[6]  <= PROD_W'(r_e[6]) * PROD_W'(r_e[0]);
        r_p[7]  <= PROD_W'(r_e[4]) * PROD_W'(r_e[2]);
        r_p[8]  <= PROD_W'(r_e[5]) * PROD_W'(r_e[3]);
        r_p[9]  <= PROD_W'(r_e[7]) * PROD_W'(r_e[1]);
        r_p[10] <= PROD_W'(r_e[7]) * PROD_W'(r_e[0]);
        r_p[11] <= PROD_W'(r_e[5]) * PROD_W'(r_e[2]);
    end

    // T * adj(R), det R and det T
    always_ff @(posedge i_clk) begin
        r_detr <= MAT_W'(r_p[0]) - MAT_W'(r_p[1]);
        r_dett <= MAT_W'(r_p[2]) - MAT_W'(r_p[3]);
        for (int i = 0; i < 4; i++) begin
            r_m[i] <= MAT_W'(r_p[4+2*i]) - MAT_W'(r_p[5+2*i]);
        end
    end

    assign n_flip = r_detr[MAT_W-1];

    always_ff @(posedge i_clk) begin
        r_den <= n_flip ? MAG_W'(-r_detr) : MAG_W'(r_detr);
        for (int i = 0; i < 4; i++) begin
            r_num[i] <= NUM_W'(r_m[i][MAT_W-1] ? MAG_W'(-r_m[i]) : MAG_W'(r_m[i])) << FRAC_BITS;
            r_neg[i] <= r_m[i][MAT_W-1] ^ n_flip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_flags <= '0;
        end else begin
            r_v1          <= i_start;
            r_v2          <= r_v1;
            r_v3          <= r_v2;
            r_flags.valid <= r_v3;
            r_flags.degen <= (r_detr == '0);
            r_flags.tzero <= (r_dett == '0);
            r_flags.dneg  <= r_dett[MAT_W-1] ^ n_flip;
        end
    end

    assign o_flags = r_flags;
    assign o_den   = r_den;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_num[i] = r_num[i];
            o_neg[i] = r_neg[i];
        end
    end

endmodule

@@ sv/tss_div.sv @@
module tss_div #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic [tss_pkg::MAG_W+FRAC_BITS-1:0]    i_num,
    input  logic [tss_pkg::MAG_W-1:0]              i_den,
    input  logic                                   i_neg,
    output logic signed [tss_pkg::ENT_W-1:0]       o_ent
);
    import tss_pkg::*;

    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int REM_W = MAG_W + 1;

    logic [REM_W-1:0] r_rem [0:QB];
    logic [QB-1:0]    r_q   [0:QB];
    logic [QB-1:0]    r_nlo [0:QB];
    logic [MAG_W-1:0] r_den [0:QB];
    logic             r_ovf [0:QB];
    logic             r_neg [0:QB];
    logic signed [ENT_W-1:0] r_ent;

    // quotient reaches 2^QB exactly when the top numerator bits are >= d
    always_ff @(posedge i_clk) begin
        r_rem[0] <= REM_W'(i_num >> QB);
        r_ovf[0] <= (i_num >> QB) >= NUM_W'(i_den);
        r_nlo[0] <= i_num[QB-1:0];
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
    end

    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb begin
            trial = {r_rem[k-1][REM_W-2:0], r_nlo[k-1][QB-1]};
            ge    = trial >= REM_W'(r_den[k-1]);
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? trial - REM_W'(r_den[k-1]) : trial;
            r_q[k]   <= {r_q[k-1][QB-2:0], ge};
            r_nlo[k] <= {r_nlo[k-1][QB-2:0], 1'b0};
            r_den[k] <= r_den[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    logic [QB-1:0] n_mag;
    assign n_mag = r_ovf[QB] ? '1 : r_q[QB];

    always_ff @(posedge i_clk) begin
        r_ent <= r_neg[QB] ? -$signed(ENT_W'(n_mag)) : $signed(ENT_W'(n_mag));
    end

    assign o_ent = r_ent;

endmodule

@@ sv/tss_sqrt.sv @@
module tss_sqrt (
    input  logic                          i_clk,
    input  logic [tss_pkg::RAD_W-1:0]     i_x,
    output logic [tss_pkg::ROOT_W-1:0]    o_root
);
    import tss_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic [REM_W-1:0]  r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];
    logic [RAD_W-1:0]  r_x    [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_root[0] <= '0;
        r_x[0]    <= i_x;
    end

    // one root bit per stage, two radicand bits shifted in
    for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
        logic [TRY_W-1:0] trial;
        logic [TRY_W-1:0] sub;
        logic             ge;

        always_comb begin
            trial = {r_rem[k-1], r_x[k-1][RAD_W-1:RAD_W-2]};
            sub   = TRY_W'({r_root[k-1], 2'b01});
            ge    = trial >= sub;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= REM_W'(ge ? trial - sub : trial);
            r_root[k] <= {r_root[k-1][ROOT_W-2:0], ge};
            r_x[k]    <= {r_x[k-1][RAD_W-3:0], 2'b00};
        end
    end

    assign o_root = r_root[ROOT_W];

endmodule

@@ sv/triangle_signed_stretch.sv @@
// channel  | ports                     | direction | transfer when
// ---------+---------------------------+-----------+-------------------
// item     | start, busy, i_item       | in        | start && !busy
// result   | o_done, o_result          | out       | o_done (one cycle)
//
// One triangle enters per clock; busy is never raised.
// Latency is set by the bit-per-stage divider and square-root pipelines.
// Synchronous active-low reset clears the valid chain; data stages are not reset.
// Results cannot be stalled, so no stage ever holds.
module triangle_signed_stretch #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tss_pkg::t_item   i_item,
    output logic             o_done,
    output tss_pkg::t_result o_result
);
    import tss_pkg::*;

    localparam int NUM_W   = MAG_W + FRAC_BITS;
    localparam int DLY_N   = DIV_LAT + ROOT_W + 5;
    localparam int TOT_LAT = FRONT_LAT + DLY_N + 1;

    t_flags                  front_flags;
    logic [NUM_W-1:0]        front_num [4];
    logic                    front_neg [4];
    logic [MAG_W-1:0]        front_den;
    logic signed [ENT_W-1:0] ent [4];

    tss_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_flags (front_flags),
        .o_num   (front_num),
        .o_neg   (front_neg),
        .o_den   (front_den)
    );

    // entries: 0 f00, 1 f01, 2 f10, 3 f11
    for (genvar i = 0; i < 4; i++) begin : g_div
        tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_num (front_num[i]),
            .i_den (front_den),
            .i_neg (front_neg[i]),
            .o_ent (ent[i])
        );
    end

    // a = f00+f11, b = f10-f01, c = f00-f11, e = f10+f01
    logic signed [SUM_W-1:0] r_s   [4];
    logic [SMAG_W-1:0]       r_mag [4];
    logic [2*HI_W-1:0]       r_hh  [4];
    logic [HI_W+LO_W-1:0]    r_hl  [4];
    logic [2*LO_W-1:0]       r_ll  [4];
    logic [SQ_W-1:0]         r_sq  [4];

    always_ff @(posedge i_clk) begin
        r_s[0] <= SUM_W'(ent[0]) + SUM_W'(ent[3]);
        r_s[1] <= SUM_W'(ent[2]) - SUM_W'(ent[1]);
        r_s[2] <= SUM_W'(ent[0]) - SUM_W'(ent[3]);
        r_s[3] <= SUM_W'(ent[2]) + SUM_W'(ent[1]);
        for (int i = 0; i < 4; i++) begin
            r_mag[i] <= r_s[i][SUM_W-1] ? SMAG_W'(-r_s[i]) : SMAG_W'(r_s[i]);
            r_hh[i]  <= (2*HI_W)'(r_mag[i][SMAG_W-1:LO_W]) * (2*HI_W)'(r_mag[i][SMAG_W-1:LO_W]);
            r_hl[i]  <= (HI_W+LO_W)'(r_mag[i][SMAG_W-1:LO_W])
                        * (HI_W+LO_W)'(r_mag[i][LO_W-1:0]);
            r_ll[i]  <= (2*LO_W)'(r_mag[i][LO_W-1:0]) * (2*LO_W)'(r_mag[i][LO_W-1:0]);
            r_sq[i]  <= (SQ_W'(r_hh[i]) << (2*LO_W)) + (SQ_W'(r_hl[i]) << (LO_W+1))
                        + SQ_W'(r_ll[i]);
        end
    end

    logic [ROOT_W-1:0] qa, rc;

    tss_sqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_x    (RAD_W'(r_sq[0]) + RAD_W'(r_sq[1])),
        .o_root (qa)
    );

    tss_sqrt u_sqrt_c (
        .i_clk  (i_clk),
        .i_x    (RAD_W'(r_sq[2]) + RAD_W'(r_sq[3])),
        .o_root (rc)
    );

    t_flags r_dly [DLY_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DLY_N; k++) begin
                r_dly[k] <= '0;
            end
        end else begin
            r_dly[0] <= front_flags;
            for (int k = 1; k < DLY_N; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    t_flags             fin;
    logic [ROOT_W:0]    n_sum;
    logic [ROOT_W-1:0]  n_diff;
    logic [ROOT_W-2:0]  n_half;
    t_result            n_res;

    assign fin = r_dly[DLY_N-1];

    always_comb begin
        n_sum  = (ROOT_W+1)'(qa) + (ROOT_W+1)'(rc);
        n_diff = (qa > rc) ? qa - rc : rc - qa;
        n_half = n_diff[ROOT_W-1:1];
        n_res  = '0;
        n_res.stretch_major = (n_sum[ROOT_W:1] > ROOT_W'(32'h7FFF_FFFF))
                              ? 31'h7FFF_FFFF : n_sum[31:1];
        if (fin.tzero) begin
            n_res.stretch_minor = '0;
        end else if (fin.dneg) begin
            n_res.stretch_minor = (n_half > (ROOT_W-1)'(33'h0_8000_0000))
                                  ? 32'sh8000_0000 : -$signed(n_half[31:0]);
        end else begin
            n_res.stretch_minor = (n_half > (ROOT_W-1)'(32'h7FFF_FFFF))
                                  ? 32'sh7FFF_FFFF : $signed(n_half[31:0]);
        end
        if (fin.degen) begin
            n_res = '0;
            n_res.rest_degenerate = 1'b1;
        end
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_res;
    end

    assign o_done = r_done;
    assign busy   = 1'b0;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.rest_degenerate |->
            o_result.stretch_major == '0 && o_result.stretch_minor == '0)
        else $error("degenerate rest triangle with nonzero stretch");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##TOT_LAT o_done)
        else $error("accepted item produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, TOT_LAT))
        else $error("result without a matching item");

endmodule

@@ tb/triangle_signed_stretch_tb.sv @@
module triangle_signed_stretch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    typedef logic signed [127:0] t_wide;
    typedef logic [127:0] t_uwide;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam t_uwide ENTRY_CAP = (t_uwide'(1) << QB) - 1;

    class stretch_board;
        t_result want_q[$];
        int      n_err;
        int      n_seen;
        int      n_degen;
        int      n_neg;

        function new();
            n_err = 0;
            n_seen = 0;
            n_degen = 0;
            n_neg = 0;
        endfunction

        // magnitude of (m * 2^FRAC) / d, truncated and capped, sign reapplied
        function automatic t_wide grad_entry(t_wide m, bit flip, t_uwide d);
            t_uwide mag;
            t_uwide q;
            bit     neg;
            if (flip) m = -m;
            neg = m < 0;
            mag = neg ? t_uwide'(-m) : t_uwide'(m);
            q = (mag << FRAC) / d;
            if (q > ENTRY_CAP) q = ENTRY_CAP;
            return neg ? -t_wide'(q) : t_wide'(q);
        endfunction

        function automatic t_uwide isqrt(t_uwide x);
            t_uwide root;
            t_uwide cand;
            root = 0;
            for (int i = 62; i >= 0; i--) begin
                cand = root | (t_uwide'(1) << i);
                if (x >= cand * cand) root = cand;
            end
            return root;
        endfunction

        function automatic t_uwide hyp(t_wide x, t_wide y);
            t_uwide ux;
            t_uwide uy;
            ux = x < 0 ? t_uwide'(-x) : t_uwide'(x);
            uy = y < 0 ? t_uwide'(-y) : t_uwide'(y);
            return isqrt(ux * ux + uy * uy);
        endfunction

        function void note(t_item it);
            t_wide   r00, r10, r01, r11, t00, t10, t01, t11;
            t_wide   detr, dett, f00, f01, f10, f11;
            t_uwide  d, qa, rc, major, mag;
            bit      flip, negative;
            t_result res;
            r00 = longint'(it.rest_bx) - longint'(it.rest_ax);
            r10 = longint'(it.rest_by) - longint'(it.rest_ay);
            r01 = longint'(it.rest_cx) - longint'(it.rest_ax);
            r11 = longint'(it.rest_cy) - longint'(it.rest_ay);
            t00 = longint'(it.goal_bx) - longint'(it.goal_ax);
            t10 = longint'(it.goal_by) - longint'(it.goal_ay);
            t01 = longint'(it.goal_cx) - longint'(it.goal_ax);
            t11 = longint'(it.goal_cy) - longint'(it.goal_ay);
            detr = r00 * r11 - r01 * r10;
            dett = t00 * t11 - t01 * t10;
            res = '0;
            if (detr == 0) begin
                res.rest_degenerate = 1'b1;
                n_degen++;
            end else begin
                flip = detr < 0;
                d = flip ? t_uwide'(-detr) : t_uwide'(detr);
                f00 = grad_entry(t00 * r11 - t01 * r10, flip, d);
                f01 = grad_entry(t01 * r00 - t00 * r01, flip, d);
                f10 = grad_entry(t10 * r11 - t11 * r10, flip, d);
                f11 = grad_entry(t11 * r00 - t10 * r01, flip, d);
                qa = hyp(f00 + f11, f10 - f01);
                rc = hyp(f00 - f11, f10 + f01);
                major = (qa + rc) >> 1;
                res.stretch_major = major > 128'h7FFF_FFFF ? 31'h7FFF_FFFF : major[30:0];
                if (dett != 0) begin
                    negative = (dett < 0) != flip;
                    mag = (qa > rc ? qa - rc : rc - qa) >> 1;
                    if (negative) begin
                        if (mag > 128'h8000_0000) mag = 128'h8000_0000;
                        res.stretch_minor = -mag[31:0];
                        if (mag != 0) n_neg++;
                    end else begin
                        res.stretch_minor = mag > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : mag[31:0];
                    end
                end
            end
            want_q.push_back(res);
        endfunction

        function void check(t_result got);
            t_result want;
            n_seen++;
            if (want_q.size() == 0) begin
                $error("result with nothing outstanding: %p", got);
                n_err++;
                return;
            end
            want = want_q.pop_front();
            if (got.stretch_major !== want.stretch_major) begin
                $error("stretch_major exp %0d got %0d", want.stretch_major, got.stretch_major);
                n_err++;
            end
            if (got.stretch_minor !== want.stretch_minor) begin
                $error("stretch_minor exp %0d got %0d", want.stretch_minor, got.stretch_minor);
                n_err++;
            end
            if (got.rest_degenerate !== want.rest_degenerate) begin
                $error("rest_degenerate exp %0b got %0b",
                       want.rest_degenerate, got.rest_degenerate);
                n_err++;
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_done;
    t_result o_result;

    stretch_board board;
    int n_items;
    bit no_gaps;

    triangle_signed_stretch uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) board.check(o_result);
    end

    task automatic send_tri(t_item it);
        while (!no_gaps && $urandom_range(0, 99) < 25) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_item <= t_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note(it);
        n_items++;
    endtask

    function automatic t_item make_tri(int rax, int ray, int rbx, int rby, int rcx, int rcy,
                                       int gax, int gay, int gbx, int gby, int gcx, int gcy);
        t_item it;
        it.rest_ax = rax; it.rest_ay = ray; it.rest_bx = rbx;
        it.rest_by = rby; it.rest_cx = rcx; it.rest_cy = rcy;
        it.goal_ax = gax; it.goal_ay = gay; it.goal_bx = gbx;
        it.goal_by = gby; it.goal_cx = gcx; it.goal_cy = gcy;
        return it;
    endfunction

    // coordinate within about +-span units in Q16.16
    function automatic int coord(int span);
        return int'($urandom_range(0, 2 * span * 65536)) - span * 65536;
    endfunction

    function automatic t_item rand_tri(int kind);
        t_item it;
        int    s;
        it = t_item'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (kind == 0) return it;
        s = (kind == 1) ? 8 : 200;
        it = make_tri(coord(s), coord(s), coord(s), coord(s), coord(s), coord(s),
                      coord(s), coord(s), coord(s), coord(s), coord(s), coord(s));
        // target as a small perturbation of the rest pose
        if ($urandom_range(0, 2) == 0) begin
            it.goal_ax = it.rest_ax + coord(1); it.goal_ay = it.rest_ay + coord(1);
            it.goal_bx = it.rest_bx + coord(1); it.goal_by = it.rest_by + coord(1);
            it.goal_cx = it.rest_cx + coord(1); it.goal_cy = it.rest_cy + coord(1);
        end
        // collinear rest or target now and then
        case ($urandom_range(0, 9))
            0: begin it.rest_cx = 2 * it.rest_bx - it.rest_ax;
                     it.rest_cy = 2 * it.rest_by - it.rest_ay; end
            1: begin it.goal_cx = it.goal_bx; it.goal_cy = it.goal_by; end
            default: ;
        endcase
        return it;
    endfunction

    localparam int MX = 32'h7FFF_FFFF;
    localparam int MN = 32'h8000_0000;
    localparam int ONE = 65536;

    initial begin
        board = new();
        n_items = 0;
        no_gaps = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity, scaled, mirrored, degenerate, flat target, extremes, saturation
        send_tri(make_tri(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE));
        send_tri(make_tri(0, 0, ONE, 0, 0, ONE, 0, 0, 3 * ONE, 0, 0, ONE / 2));
        send_tri(make_tri(0, 0, ONE, 0, 0, ONE, 0, 0, -ONE, 0, 0, 2 * ONE));
        send_tri(make_tri(0, 0, 0, ONE, ONE, 0, 0, 0, ONE, 0, 0, ONE));
        send_tri('0);
        send_tri(make_tri(5, 7, 5, 7, 5, 7, 0, 0, ONE, 0, 0, ONE));
        send_tri(make_tri(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 0, 0, ONE, 0, 0, ONE));
        send_tri(make_tri(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE));
        send_tri(make_tri(0, 0, ONE, 0, 0, ONE, 1, 1, 1, 1, 1, 1));
        send_tri(make_tri(MN, MN, MX, MN, MN, MX, MN, MN, MX, MN, MN, MX));
        send_tri(make_tri(MN, MN, MX, MN, MN, MX, MN, MN, MN, MX, MX, MN));
        send_tri(make_tri(MX, MX, MN, MX, MX, MN, MN, MN, MX, MN, MN, MX));
        send_tri(make_tri(0, 0, 1, 0, 0, 1, MN, MN, MX, MN, MN, MX));
        send_tri(make_tri(0, 0, 1, 0, 0, 1, MN, MN, MN, MX, MX, MN));
        send_tri(make_tri(0, 0, 1, 0, 0, 1, 0, 0, ONE, 0, 0, ONE));
        send_tri(make_tri(0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, -1));
        send_tri(make_tri(MN, MN, MX, MX, MN, MN + 1, MX, MX, MN, MN, MX, MN));
        send_tri(make_tri(MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX, MX));
        send_tri(make_tri(MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN));
        send_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));

        for (int i = 0; i < 1130; i++) begin
            no_gaps = (i >= 400 && i < 650);
            send_tri(rand_tri($urandom_range(0, 99) < 20 ? 0 : $urandom_range(1, 2)));
        end
        @(negedge i_clk);
        start <= 1'b0;

        for (int w = 0; w < 2000 && board.want_q.size() != 0; w++) @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (board.want_q.size() != 0) begin
            $error("%0d results never arrived", board.want_q.size());
            board.n_err++;
        end
        $display("sent %0d triangles, checked %0d results", n_items, board.n_seen);
        $display("degenerate rest: %0d, negative minor stretch: %0d",
                 board.n_degen, board.n_neg);
        if (board.n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule
